// ----- design/ddw_pkg.sv -----
// Shared types, widths and calendar tables for the date difference block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ddw_pkg;

	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int YEAR_W    = 14;
	localparam int DNUM_W    = 23;   // closed-form day number for years up to 16383
	localparam int DAYS_W    = 22;
	localparam int WDAY_W    = 3;
	localparam int Q100_W    = 8;    // year / 100 fits in 8 bits
	localparam int ZSUM_W    = 11;   // Zeller sum before mod 7
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 32;

	// reciprocal of 100 scaled by 2^19, exact for 14-bit dividends
	localparam int RECIP100      = 5243;
	localparam int RECIP100_SHR  = 19;
	localparam int RECIP100_PW   = YEAR_W + 13;

	// 2^16/7 rounded up; exact for sums below 2^11
	localparam int RECIP7     = 9363;
	localparam int RECIP7_SHR = 16;
	localparam int RECIP7_PW  = ZSUM_W + 14;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_ctrl_t;

	typedef struct packed {
		logic                  valid;
		logic [DNUM_W-1:0]     day_num;
		logic [ZSUM_W-1:0]     zsum;
	} lane_out_t;

	// length of month; zero for codes that are no month, so the date fails
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// (153*mm + 2) / 5 with March as month zero
	function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [8:0] off;
		unique case (m)
			4'd3:    off = 9'd0;
			4'd4:    off = 9'd31;
			4'd5:    off = 9'd61;
			4'd6:    off = 9'd92;
			4'd7:    off = 9'd122;
			4'd8:    off = 9'd153;
			4'd9:    off = 9'd184;
			4'd10:   off = 9'd214;
			4'd11:   off = 9'd245;
			4'd12:   off = 9'd275;
			4'd1:    off = 9'd306;
			4'd2:    off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

	// Zeller month term 13*(mm+1)/5, Jan and Feb counted as months 13 and 14
	function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
		logic [5:0] t;
		unique case (m)
			4'd1:    t = 6'd36;
			4'd2:    t = 6'd39;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

	// floor(v / 100) for v below 2^14
	function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] v);
		logic [RECIP100_PW-1:0] p;
		p = RECIP100_PW'(v) * RECIP100_PW'(RECIP100);
		return Q100_W'(p >> RECIP100_SHR);
	endfunction

endpackage

`default_nettype wire

// ----- design/ddw_lane.sv -----
// One date lane: validity check, closed-form day number and Zeller sum.
// Two pipeline stages; depends on ddw_pkg.
`default_nettype none

module ddw_lane import ddw_pkg::*; (
	input  wire logic                 clk,
	input  wire pipe_ctrl_t           ctrl,
	input  wire logic [DAY_W-1:0]     day,
	input  wire logic [MONTH_W-1:0]   month,
	input  wire logic [YEAR_W-1:0]    year,
	output lane_out_t                 lane_out
);

	logic [YEAR_W-1:0]  yy;
	logic [DAY_W-1:0]   d_s1;
	logic [MONTH_W-1:0] m_s1;
	logic [YEAR_W-1:0]  y_s1;
	logic [YEAR_W-1:0]  yy_s1;
	logic [Q100_W-1:0]  qy_s1;
	logic [Q100_W-1:0]  qyy_s1;
	logic [DNUM_W-1:0]  yy365_s1;

	logic [6:0]         ry;
	logic [6:0]         k;
	logic               leap;
	logic               date_ok;
	logic [DNUM_W-1:0]  day_num;
	logic [ZSUM_W-1:0]  zsum;

	// Jan and Feb belong to the previous year in both formulas
	assign yy = (month < MONTH_MAR) ? year - 14'd1 : year;

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			d_s1     <= day;
			m_s1     <= month;
			y_s1     <= year;
			yy_s1    <= yy;
			qy_s1    <= div100(year);
			qyy_s1   <= div100(yy);
			yy365_s1 <= DNUM_W'(yy) * DNUM_W'(365);
		end
	end

	always_comb begin
		ry   = 7'(y_s1 - YEAR_W'(qy_s1) * YEAR_W'(100));
		k    = 7'(yy_s1 - YEAR_W'(qyy_s1) * YEAR_W'(100));
		leap = (y_s1[1:0] == 2'd0) && ((ry != 7'd0) || (qy_s1[1:0] == 2'd0));
		date_ok = (y_s1 != '0) && (d_s1 != '0) && (d_s1 <= month_len(m_s1, leap));
		day_num = yy365_s1 + DNUM_W'(yy_s1 >> 2) - DNUM_W'(qyy_s1)
			+ DNUM_W'(qyy_s1 >> 2) + DNUM_W'(month_offset(m_s1))
			+ DNUM_W'(d_s1) - DNUM_W'(1);
		zsum = ZSUM_W'(d_s1) + ZSUM_W'(zeller_month(m_s1)) + ZSUM_W'(k)
			+ ZSUM_W'(k >> 2) + ZSUM_W'(qyy_s1 >> 2) + ZSUM_W'(qyy_s1) * ZSUM_W'(5);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			lane_out.valid   <= date_ok;
			lane_out.day_num <= day_num;
			lane_out.zsum    <= zsum;
		end
	end

endmodule

`default_nettype wire

// ----- design/ddw_merge.sv -----
// Merge stage: day count from the two lanes, saturation, weekdays mod 7.
// One register stage; depends on ddw_pkg.
`default_nettype none

module ddw_merge import ddw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en_s3,
	input  wire lane_out_t          start_lane,
	input  wire lane_out_t          end_lane,
	output logic                    dates_valid_s3,
	output logic [DAYS_W-1:0]       days_between_s3,
	output logic [WDAY_W-1:0]       start_weekday_s3,
	output logic [WDAY_W-1:0]       end_weekday_s3
);

	logic               both_ok;
	logic [DNUM_W-1:0]  diff;
	logic [DAYS_W-1:0]  days;

	function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] x);
		logic [RECIP7_PW-1:0] p;
		logic [ZSUM_W-1:0]    q;
		p = RECIP7_PW'(x) * RECIP7_PW'(RECIP7);
		q = ZSUM_W'(p >> RECIP7_SHR);
		return WDAY_W'(x - q * ZSUM_W'(7));
	endfunction

	always_comb begin
		both_ok = start_lane.valid && end_lane.valid;
		diff    = (end_lane.day_num > start_lane.day_num)
			? end_lane.day_num - start_lane.day_num : '0;
		days    = diff[DNUM_W-1] ? '1 : diff[DAYS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			dates_valid_s3   <= both_ok;
			days_between_s3  <= both_ok ? days : '0;
			start_weekday_s3 <= both_ok ? mod7(start_lane.zsum) : '0;
			end_weekday_s3   <= both_ok ? mod7(end_lane.zsum) : '0;
		end
	end

endmodule

`default_nettype wire

// ----- design/date_difference_and_weekday_top.sv -----
// Top level of the date difference and weekday block: stream ports,
// pipeline valid tracking, two ddw_lane instances and ddw_merge.
`default_nettype none

// Each request carries a start and an end Gregorian date. Both are checked
// (year 1 or more, month 1..12, day within the month with the leap rule);
// the result gives the day count from start to end (0 when the end is not
// later, saturating at the 22-bit maximum), and each date's weekday with
// 0 = Saturday. A request that holds an invalid date yields tuser = 0 and
// all-zero tdata. The block takes one request per clock unless m_tready
// stalls a full pipeline: one date lane per date runs two stages
// (reciprocal divides by 100, then day number and Zeller sum), and the merge
// stage registers the difference and the mod-7 weekdays. Each stage holds
// only while its successor is full and stalled, so requests keep flowing
// into empty stages while a finished result waits on the output.

module date_difference_and_weekday_top import ddw_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// [4:0] start_day, [8:5] start_month, [22:9] start_year,
	// [27:23] end_day, [31:28] end_month, [45:32] end_year, [47:46] zero
	input  wire logic [IN_DATA_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// [21:0] days_between, [24:22] start_weekday, [27:25] end_weekday, [31:28] zero
	output logic [OUT_DATA_W-1:0]        m_tdata,
	// [0] dates_valid
	output logic                         m_tuser
);

	logic        v_s1_q, v_s2_q, v_s3_q;
	logic        en_s1, en_s2, en_s3;
	pipe_ctrl_t  lane_ctrl;
	lane_out_t   start_lane, end_lane;
	logic              dates_valid_s3;
	logic [DAYS_W-1:0] days_between_s3;
	logic [WDAY_W-1:0] start_weekday_s3;
	logic [WDAY_W-1:0] end_weekday_s3;

	assign en_s3 = !v_s3_q || m_tready;
	assign en_s2 = !v_s2_q || en_s3;
	assign en_s1 = !v_s1_q || en_s2;
	assign s_tready = en_s1;
	assign lane_ctrl = '{en_s1: en_s1, en_s2: en_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			if (en_s1) v_s1_q <= s_tvalid;
			if (en_s2) v_s2_q <= v_s1_q;
			if (en_s3) v_s3_q <= v_s2_q;
		end
	end

	ddw_lane u_start_lane (
		.clk      (clk),
		.ctrl     (lane_ctrl),
		.day      (s_tdata[4:0]),
		.month    (s_tdata[8:5]),
		.year     (s_tdata[22:9]),
		.lane_out (start_lane)
	);

	ddw_lane u_end_lane (
		.clk      (clk),
		.ctrl     (lane_ctrl),
		.day      (s_tdata[27:23]),
		.month    (s_tdata[31:28]),
		.year     (s_tdata[45:32]),
		.lane_out (end_lane)
	);

	ddw_merge u_merge (
		.clk              (clk),
		.en_s3            (en_s3),
		.start_lane       (start_lane),
		.end_lane         (end_lane),
		.dates_valid_s3   (dates_valid_s3),
		.days_between_s3  (days_between_s3),
		.start_weekday_s3 (start_weekday_s3),
		.end_weekday_s3   (end_weekday_s3)
	);

	assign m_tvalid = v_s3_q;
	assign m_tuser  = dates_valid_s3;
	assign m_tdata  = {4'd0, end_weekday_s3, start_weekday_s3, days_between_s3};

`ifndef SYNTHESIS
	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("output empty but request not accepted");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1_q)
		else $error("accepted request lost before first stage");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("invalid date result carries nonzero data");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((start_weekday_s3 != 3'd7) && (end_weekday_s3 != 3'd7)))
		else $error("weekday out of range");
`endif

endmodule

`default_nettype wire
